// ===== sv/max_tracking_stack_assert.svh =====
// assertion macros used by the stack datapath
`ifndef MAX_TRACKING_STACK_ASSERT_SVH
`define MAX_TRACKING_STACK_ASSERT_SVH

// condition in the same cycle
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in the following cycle
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/mts_pkg.sv =====
package mts_pkg;

  // command codes of an input word
  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_QUERY = 2'd0;
  localparam cmd_t CMD_PUSH  = 2'd1;
  localparam cmd_t CMD_POP   = 2'd2;

  // error codes of a result word
  typedef logic [1:0] err_t;
  localparam err_t ERR_OK    = 2'd0;
  localparam err_t ERR_EMPTY = 2'd1;
  localparam err_t ERR_FULL  = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic exec;
    logic push;
    logic pop;
    logic load_top;
    logic load_out;
    err_t err_code;
  } ctrl_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic empty;
    logic full;
    logic one_left;
  } stat_t;

endpackage

// ===== sv/mts_datapath.sv =====
`include "max_tracking_stack_assert.svh"

module mts_datapath import mts_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctrl_t                       ctrl,
  output stat_t                       stat,
  input  logic [1:0]                  command,
  input  logic signed [WORD_BITS-1:0] value,
  output logic signed [WORD_BITS-1:0] top_value,
  output logic signed [WORD_BITS-1:0] max_value,
  output logic                        is_empty,
  output logic                        is_full,
  output logic [1:0]                  error
);

  localparam int CNT_BITS  = $clog2(DEPTH + 1);
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(DEPTH);

  // levels below the top, the top itself sits in registers
  logic signed [WORD_BITS-1:0] entry_mem [DEPTH];
  logic signed [WORD_BITS-1:0] rmax_mem  [DEPTH];

  cmd_t                        cmd_q;
  logic signed [WORD_BITS-1:0] val_q;
  logic signed [WORD_BITS-1:0] top_reg;
  logic signed [WORD_BITS-1:0] max_reg;
  logic signed [WORD_BITS-1:0] rd_entry;
  logic signed [WORD_BITS-1:0] rd_max;
  logic [CNT_BITS-1:0]         count;
  err_t                        err_q;

  logic [CNT_BITS-1:0]         count_m1;
  logic [CNT_BITS-1:0]         count_m2;
  logic [ADDR_BITS-1:0]        wr_addr;
  logic [ADDR_BITS-1:0]        rd_addr;
  logic signed [WORD_BITS-1:0] push_max;

  // addresses around the top level
  assign count_m1 = count - CNT_BITS'(1);
  assign count_m2 = count - CNT_BITS'(2);
  assign wr_addr  = count_m1[ADDR_BITS-1:0];
  assign rd_addr  = count_m2[ADDR_BITS-1:0];

  // running maximum for a new level, ties keep the older maximum
  assign push_max = ((count != '0) && !(val_q > max_reg)) ? max_reg : val_q;

  // status towards the controller
  assign stat.is_push  = (cmd_q == CMD_PUSH);
  assign stat.is_pop   = (cmd_q == CMD_POP);
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == FULL_COUNT);
  assign stat.one_left = (count == CNT_BITS'(1));

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CNT_BITS'(1);
    end else if (ctrl.pop) begin
      count <= count_m1;
    end
  end

  // input word capture, top registers and error code
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q <= command;
      val_q <= value;
    end
    if (ctrl.exec) begin
      err_q <= ctrl.err_code;
    end
    if (ctrl.push) begin
      top_reg <= val_q;
      max_reg <= push_max;
    end else if (ctrl.load_top) begin
      top_reg <= rd_entry;
      max_reg <= rd_max;
    end
  end

  // stack memory: spill the old top on push, fetch the level below on pop
  always_ff @(posedge clk) begin
    if (ctrl.push && (count != '0)) begin
      entry_mem[wr_addr] <= top_reg;
      rmax_mem[wr_addr]  <= max_reg;
    end
    if (ctrl.pop) begin
      rd_entry <= entry_mem[rd_addr];
      rd_max   <= rmax_mem[rd_addr];
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      top_value <= (count == '0) ? '0 : top_reg;
      max_value <= (count == '0) ? '0 : max_reg;
      is_empty  <= (count == '0);
      is_full   <= (count == FULL_COUNT);
      error     <= err_q;
    end
  end

  `MTS_ASSERT_NOW(a_count_range, 1'b1, count <= FULL_COUNT, "fill count beyond depth")
  `MTS_ASSERT_NOW(a_push_not_full, ctrl.push, count != FULL_COUNT, "push issued on full stack")
  `MTS_ASSERT_NOW(a_pop_not_empty, ctrl.pop, count != '0, "pop issued on empty stack")
  `MTS_ASSERT_NEXT(a_push_count, ctrl.push, count == ($past(count) + CNT_BITS'(1)), "push count slip")

endmodule

// ===== sv/mts_controller.sv =====
module mts_controller import mts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD,
    S_RESULT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // command decode per state
  always_comb begin
    ctrl          = '0;
    ctrl.err_code = ERR_OK;
    ctrl.capture  = (state == S_IDLE) && in_valid;
    case (state)
      S_EXEC: begin
        ctrl.exec = 1'b1;
        if (stat.is_push) begin
          if (stat.full) begin
            ctrl.err_code = ERR_FULL;
          end else begin
            ctrl.push = 1'b1;
          end
        end else if (stat.is_pop) begin
          if (stat.empty) begin
            ctrl.err_code = ERR_EMPTY;
          end else begin
            ctrl.pop = 1'b1;
          end
        end
      end
      S_LOAD: begin
        ctrl.load_top = 1'b1;
      end
      S_RESULT: begin
        ctrl.load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          // a pop that leaves entries needs the level below from memory
          if (stat.is_pop && !stat.empty && !stat.one_left) begin
            state <= S_LOAD;
          end else begin
            state <= S_RESULT;
          end
        end
        S_LOAD: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/max_tracking_stack.sv =====
// channel  | handshake            | payload
// input    | in_valid / in_stall  | command, value
// output   | out_valid / out_stall| top_value, max_value, is_empty, is_full, error
//
// query, push and refused commands pass S_EXEC and then S_RESULT; a pop that leaves
// entries also passes S_LOAD for the stack memory read of the level below the top;
// the next word is accepted only once the controller is back in S_IDLE
// rst clears the fill count, returns the controller to idle and drops out_valid,
// the stack memory is not cleared
// a new word is accepted while the previous result waits under out_stall

module max_tracking_stack import mts_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  command,
  input  logic signed [WORD_BITS-1:0] value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] top_value,
  output logic signed [WORD_BITS-1:0] max_value,
  output logic                        is_empty,
  output logic                        is_full,
  output logic [1:0]                  error
);

  ctrl_t ctrl;
  stat_t stat;

  // sequencing
  mts_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // stack storage and result word
  mts_datapath #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .stat      (stat),
    .command   (command),
    .value     (value),
    .top_value (top_value),
    .max_value (max_value),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .error     (error)
  );

endmodule

// ===== dv/max_tracking_stack_test.sv =====
module max_tracking_stack_test import mts_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 64;
  localparam int WORD_BITS   = 32;
  localparam int N_DIRECTED  = 25;
  localparam int RANDOM_WORDS = 1050;
  localparam int PHASE_WORDS = 350;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = N_DIRECTED + 2 * PHASE_WORDS + 30;
  localparam int DRAIN_WAIT  = 20;
  localparam int CYCLE_LIMIT = 100000;

  // command code with no operation of its own, behaves as a query
  localparam cmd_t CMD_SPARE = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t top_word;
    word_t max_word;
    logic  empty;
    logic  full;
    err_t  err;
  } stack_result_t;

  typedef struct packed {
    cmd_t          cmd;
    word_t         val;
    logic          typed;
    stack_result_t res;
  } stack_row_t;

  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} mix_mode_t;

  localparam word_t W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
  localparam word_t W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};

  // directed words, expected result typed in where it is obvious
  stack_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_QUERY, 32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0, ERR_OK}},
    '{CMD_POP,   32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0, ERR_EMPTY}},
    '{CMD_SPARE, 32'h1234_5678, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0, ERR_OK}},
    '{CMD_PUSH,  W_MIN,         1'b1, '{W_MIN, W_MIN, 1'b0, 1'b0, ERR_OK}},
    '{CMD_PUSH,  W_MAX,         1'b1, '{W_MAX, W_MAX, 1'b0, 1'b0, ERR_OK}},
    '{CMD_PUSH,  32'hffff_ffff, 1'b0, '0},
    '{CMD_PUSH,  W_MAX,         1'b0, '0},
    '{CMD_QUERY, 32'hffff_ffff, 1'b0, '0},
    '{CMD_POP,   32'hdead_beef, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0, ERR_OK}},
    '{CMD_POP,   32'h5555_aaaa, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0, ERR_EMPTY}},
    '{CMD_PUSH,  32'h0000_0005, 1'b0, '0},
    '{CMD_PUSH,  32'h0000_0003, 1'b0, '0},
    '{CMD_PUSH,  32'h0000_0009, 1'b0, '0},
    '{CMD_PUSH,  32'h0000_0009, 1'b0, '0},
    '{CMD_SPARE, 32'haaaa_5555, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_PUSH,  32'hffff_fff9, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b0, '0},
    '{CMD_POP,   32'h0000_0000, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0, ERR_EMPTY}}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  logic [1:0]  command   = CMD_QUERY;
  word_t       value     = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  word_t       top_value;
  word_t       max_value;
  logic        is_empty;
  logic        is_full;
  logic [1:0]  error;

  // shadow copy of the stack and its per-level peaks
  word_t         shadow_entries [DEPTH];
  word_t         shadow_peaks   [DEPTH];
  int            shadow_level = 0;

  stack_row_t    command_words [$];
  stack_result_t pending_results [$];
  stack_result_t predicted;
  stack_result_t oldest;
  int            words_in    = 0;
  int            words_out   = 0;
  int            error_count = 0;
  int            cycle_count = 0;
  int            hold_left   = 0;
  bit            hold_done   = 1'b0;

  max_tracking_stack #(.DEPTH(DEPTH), .WORD_BITS(WORD_BITS)) DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one command to the shadow stack and return its result word
  function automatic stack_result_t stack_apply(cmd_t cmd, word_t val);
    stack_result_t r;
    word_t         peak;
    r.err = ERR_OK;
    if (cmd == CMD_PUSH) begin
      if (shadow_level == DEPTH) begin
        r.err = ERR_FULL;
      end else begin
        peak = val;
        // ties keep the older peak
        if (shadow_level > 0 && !(val > shadow_peaks[shadow_level-1]))
          peak = shadow_peaks[shadow_level-1];
        shadow_entries[shadow_level] = val;
        shadow_peaks[shadow_level]   = peak;
        shadow_level++;
      end
    end else if (cmd == CMD_POP) begin
      if (shadow_level == 0) r.err = ERR_EMPTY;
      else shadow_level--;
    end
    r.top_word = (shadow_level == 0) ? '0 : shadow_entries[shadow_level-1];
    r.max_word = (shadow_level == 0) ? '0 : shadow_peaks[shadow_level-1];
    r.empty    = (shadow_level == 0);
    r.full     = (shadow_level == DEPTH);
    return r;
  endfunction

  // extremes, near-zero ties and plain random words
  function automatic word_t random_word();
    case ($urandom_range(9))
      0: return W_MAX;
      1: return W_MIN;
      2, 3: return word_t'(int'($urandom_range(8)) - 4);
      4: return '0;
      default: return word_t'($urandom);
    endcase
  endfunction

  // fill and drain runs with random content, plus mixed stretches
  task automatic add_random_words(int amount);
    stack_row_t w;
    mix_mode_t  mode;
    int         level;
    int         roll;
    int         edge_hits;
    int         hit_limit;
    int         span;
    mode      = MODE_FILL;
    level     = 0;
    edge_hits = 0;
    hit_limit = 3;
    span      = 50;
    for (int i = 0; i < amount; i++) begin
      roll = $urandom_range(99);
      case (mode)
        MODE_FILL:  w.cmd = roll < 85 ? CMD_PUSH : roll < 93 ? CMD_POP :
                            roll < 97 ? CMD_QUERY : CMD_SPARE;
        MODE_DRAIN: w.cmd = roll < 85 ? CMD_POP : roll < 93 ? CMD_PUSH :
                            roll < 97 ? CMD_QUERY : CMD_SPARE;
        default:    w.cmd = roll < 45 ? CMD_PUSH : roll < 85 ? CMD_POP :
                            roll < 95 ? CMD_QUERY : CMD_SPARE;
      endcase
      w.val   = random_word();
      w.typed = 1'b0;
      w.res   = '0;
      command_words.push_back(w);
      if (w.cmd == CMD_PUSH && level < DEPTH) level++;
      else if (w.cmd == CMD_POP && level > 0) level--;
      // switch mode after more than hit_limit words at the full or empty edge, or when a mixed span runs out
      if (mode == MODE_FILL && level == DEPTH) edge_hits++;
      else if (mode == MODE_DRAIN && level == 0) edge_hits++;
      else if (mode == MODE_MIXED) span--;
      if (edge_hits > hit_limit || span == 0) begin
        mode      = mix_mode_t'($urandom_range(2));
        edge_hits = 0;
        hit_limit = $urandom_range(1, 4);
        span      = $urandom_range(30, 80);
      end
    end
  endtask

  // print one mismatch line and count it
  task automatic report_mismatch(string field, logic [WORD_BITS-1:0] got,
                                 logic [WORD_BITS-1:0] want);
    $display("mismatch at result word %0d: %s got %h want %h", words_out, field, got, want);
    error_count++;
  endtask

  // input side: offer words, predict on each accepted word
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = stack_apply(command_words[0].cmd, command_words[0].val);
        pending_results.push_back(command_words[0].typed ? command_words[0].res : predicted);
        void'(command_words.pop_front());
        words_in++;
      end
      if (!in_valid || !in_stall) begin
        if (command_words.size() != 0 &&
            $urandom_range(99) >= (words_in < N_DIRECTED + PHASE_WORDS ? 21 :
                                   words_in < N_DIRECTED + 2 * PHASE_WORDS ? 72 : 0)) begin
          in_valid <= 1'b1;
          command  <= command_words[0].cmd;
          value    <= command_words[0].val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: random stall, one long hold-off, compare each word
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected word, top_value", top_value, '0);
        end else begin
          oldest = pending_results.pop_front();
          if (top_value !== oldest.top_word) report_mismatch("top_value", top_value, oldest.top_word);
          if (max_value !== oldest.max_word) report_mismatch("max_value", max_value, oldest.max_word);
          if (is_empty !== oldest.empty) report_mismatch("is_empty", is_empty, oldest.empty);
          if (is_full !== oldest.full) report_mismatch("is_full", is_full, oldest.full);
          if (error !== oldest.err) report_mismatch("error", error, oldest.err);
        end
        words_out++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && words_out >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < (words_out < N_DIRECTED + PHASE_WORDS ? 72 :
                                           words_out < N_DIRECTED + 2 * PHASE_WORDS ? 21 : 0);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // build the stimulus, release reset, wait for the last word
  initial begin
    foreach (directed_rows[i]) command_words.push_back(directed_rows[i]);
    add_random_words(RANDOM_WORDS);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (command_words.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
